>>> hdl/newton_square_root_defines.svh
// ----------------------------------------------------------------------------
// Newton square root assertion macros
// Shared concurrent assertion forms for the square root block.
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSR_ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("square root check failed");

// The consequent must hold in the cycle after the antecedent.
`define NSR_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("square root check failed");

`endif

>>> hdl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// Newton square root package
// Field widths, limits and the sequencer state type.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int RAD_W  = 32;
	localparam int ITER_W = 5;
	localparam int ROOT_W = 31;

	localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

endpackage

>>> hdl/newton_square_root.sv
// ----------------------------------------------------------------------------
// Newton square root
// Heron iteration on a Q16.16 radicand with one shared serial divider.
//
// The input channel takes a request of a signed radicand and an iteration
// count when in_valid is high and in_stall is low. The output channel
// offers the unsigned root on out_valid and holds it while out_stall is
// high. A nonpositive radicand gives zero, and counts above MAX_ITERATIONS
// are saturated. Each refinement step runs a restoring divider of the
// scaled radicand by the estimate, one quotient bit per cycle, then
// forms the mean and clamps it. A request with n steps passes n rounds of
// the divide and update states and then the hold state, which registers
// the result and raises out_valid; with zero steps or a nonpositive
// radicand it goes straight to the hold state. Only one request is in work at a time; in_stall is high from
// acceptance until the result enters the output register, which waits
// while the receiver stalls a previous result, so the next request can be
// taken in the cycle in which out_valid rises. Reset empties the sequencer and
// the output register; no request is held over.
// ----------------------------------------------------------------------------
`include "newton_square_root_defines.svh"

module newton_square_root #(
	parameter int MAX_ITERATIONS = 16,
	parameter int FRAC_BITS      = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [nsr_pkg::RAD_W-1:0]   radicand,
	input  logic        [nsr_pkg::ITER_W-1:0]  iterations,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [nsr_pkg::ROOT_W-1:0]  root
);

	import nsr_pkg::*;

	localparam int DW     = ROOT_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(DW);
	localparam int CNT_W  = $clog2(MAX_ITERATIONS + 1);

	state_t              state_q;
	logic [CNT_W-1:0]    iter_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic [ROOT_W-1:0]   rad_q;
	logic [ROOT_W-1:0]   x_q;
	logic [ROOT_W-1:0]   rem_q;
	logic [DW-1:0]       quo_q;

	logic                in_acc;
	logic                out_free;
	logic                nonpos;
	logic [CNT_W-1:0]    steps;
	logic [ROOT_W-1:0]   start_x;
	logic [ROOT_W:0]     rem_sh;
	logic [ROOT_W+1:0]   diff;
	logic                bit_ok;
	logic [DW:0]         sum;
	logic [DW-1:0]       half;
	logic [ROOT_W-1:0]   next_x;
	logic [DW-1:0]       dividend;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign nonpos   = radicand[RAD_W-1] || (radicand == '0);
	assign steps    = (int'(iterations) > MAX_ITERATIONS) ? CNT_W'(MAX_ITERATIONS)
	                                                      : CNT_W'(iterations);
	assign start_x  = (radicand[ROOT_W-1:1] == '0) ? ROOT_W'(1)
	                                               : {1'b0, radicand[ROOT_W-1:1]};
	assign dividend = {rad_q, {FRAC_BITS{1'b0}}};

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, x_q};
	assign bit_ok = !diff[ROOT_W+1];

	assign sum  = {1'b0, quo_q} + {{(DW+1-ROOT_W){1'b0}}, x_q};
	assign half = sum[DW:1];

	always_comb begin
		if (half == '0) begin
			next_x = ROOT_W'(1);
		end else if (half[DW-1:ROOT_W] != '0) begin
			next_x = ROOT_MAX;
		end else begin
			next_x = half[ROOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						iter_q <= steps;
						dcnt_q <= DCNT_W'(DW - 1);
						if (nonpos || (steps == '0)) begin
							state_q <= ST_HOLD;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					iter_q <= iter_q - 1'b1;
					dcnt_q <= DCNT_W'(DW - 1);
					if (iter_q == CNT_W'(1)) begin
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rad_q <= radicand[ROOT_W-1:0];
					rem_q <= '0;
					quo_q <= {radicand[ROOT_W-1:0], {FRAC_BITS{1'b0}}};
					x_q   <= nonpos ? '0 : start_x;
				end
			end
			ST_DIV: begin
				rem_q <= bit_ok ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
				quo_q <= {quo_q[DW-2:0], bit_ok};
			end
			ST_UPD: begin
				x_q   <= next_x;
				rem_q <= '0;
				quo_q <= dividend;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			root <= x_q;
		end
	end

	`NSR_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_acc, state_q != ST_IDLE)
	`NSR_ASSERT_NEXT(a_nonpos_gives_zero, clk, arst_n, in_acc && nonpos, (state_q == ST_HOLD) && (x_q == '0))
	`NSR_ASSERT_SAME(a_divisor_nonzero, clk, arst_n, state_q == ST_DIV, x_q != '0)
	`NSR_ASSERT_SAME(a_rem_below_divisor, clk, arst_n, state_q == ST_DIV, rem_q < x_q)
	`NSR_ASSERT_NEXT(a_update_exits, clk, arst_n, state_q == ST_UPD, (state_q == ST_DIV) || (state_q == ST_HOLD))

endmodule
